/* sv/mi3_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_pkg: shared types and constants for the 3x3 matrix inverse
// Element format, derived datapath widths, cofactor index table and the
// packed transaction types of both directions.
// ----------------------------------------------------------------------------
package mi3_pkg;

    // element format, signed Q16.16
    localparam int EW    = 32;
    localparam int FB    = 16;
    localparam int THR_W = 16;

    // datapath widths
    localparam int PW    = 2 * EW;           // element products, adjugate
    localparam int TW    = 3 * EW;           // one determinant term
    localparam int DETW  = 3 * EW + 1;       // determinant, signed
    localparam int MAGW  = 3 * EW;           // determinant magnitude
    localparam int SHN   = 2 * FB + 1;       // numerator shift, incl. rounding bit
    localparam int XA    = PW - 1 + SHN;     // width of |adj| << SHN
    localparam int RW    = ((XA > MAGW) ? XA : MAGW) + 1;  // dividend / remainder
    localparam int DVW   = MAGW + 1;         // divisor, 2*|det|
    localparam int QW    = EW + 1;           // quotient bits kept
    localparam int NDIV  = EW + 2;           // divider stages, first is overflow test
    localparam int CW    = DVW + NDIV;       // compare width of the shifted divisor

    // clamp limits on the quotient magnitude
    localparam logic [QW-1:0] LIM_POS = QW'((64'd1 << (EW - 1)) - 64'd1);
    localparam logic [QW-1:0] LIM_NEG = QW'(64'd1 << (EW - 1));

    // cofactor terms: adj[k] = a[t0]*a[t1] - a[t2]*a[t3], row-major indexes
    localparam logic [0:8][0:3][3:0] ADJ_TERMS = '{
        '{4'd4, 4'd8, 4'd5, 4'd7}, '{4'd2, 4'd7, 4'd1, 4'd8}, '{4'd1, 4'd5, 4'd2, 4'd4},
        '{4'd5, 4'd6, 4'd3, 4'd8}, '{4'd0, 4'd8, 4'd2, 4'd6}, '{4'd2, 4'd3, 4'd0, 4'd5},
        '{4'd3, 4'd7, 4'd4, 4'd6}, '{4'd1, 4'd6, 4'd0, 4'd7}, '{4'd0, 4'd4, 4'd1, 4'd3}
    };

    // input transaction: the matrix, row-major
    typedef struct packed {
        logic signed [EW-1:0] m00;
        logic signed [EW-1:0] m01;
        logic signed [EW-1:0] m02;
        logic signed [EW-1:0] m10;
        logic signed [EW-1:0] m11;
        logic signed [EW-1:0] m12;
        logic signed [EW-1:0] m20;
        logic signed [EW-1:0] m21;
        logic signed [EW-1:0] m22;
    } mat_in_t;

    // result transaction: the inverse and flags
    typedef struct packed {
        logic signed [EW-1:0] r00;
        logic signed [EW-1:0] r01;
        logic signed [EW-1:0] r02;
        logic signed [EW-1:0] r10;
        logic signed [EW-1:0] r11;
        logic signed [EW-1:0] r12;
        logic signed [EW-1:0] r20;
        logic signed [EW-1:0] r21;
        logic signed [EW-1:0] r22;
        logic                 singular;
        logic                 saturated;
    } mat_out_t;

endpackage

/* sv/matrix3_inverse.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix3_inverse: 3x3 Q16.16 matrix inverse by adjugate and determinant
// Throughput: one matrix per cycle; busy stays low, one result per matrix.
// 43 register stages; each divider stage but the overflow test gives a quotient bit.
// Reset clears all valid bits and sets zero_threshold to 1; the receiver cannot stall.
// ----------------------------------------------------------------------------
module matrix3_inverse (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  mi3_pkg::mat_in_t            matrix,
    output logic                        done,
    output mi3_pkg::mat_out_t           result,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [mi3_pkg::THR_W-1:0]   cfg_data
);
    import mi3_pkg::*;

    // threshold register
    logic [THR_W-1:0] thr_reg;

    // stage 0: input capture
    logic                 s0_v_reg;
    logic signed [EW-1:0] s0_a_reg [0:8];
    logic signed [EW-1:0] s0_a_next [0:8];

    // stage 1: cofactor products
    logic                 s1_v_reg;
    logic signed [PW-1:0] s1_pa_reg [0:8];
    logic signed [PW-1:0] s1_pb_reg [0:8];
    logic signed [PW-1:0] s1_pa_next [0:8];
    logic signed [PW-1:0] s1_pb_next [0:8];
    logic signed [EW-1:0] s1_row_reg [0:2];

    // stage 2: adjugate
    logic                 s2_v_reg;
    logic signed [PW-1:0] s2_adj_reg [0:8];
    logic signed [PW-1:0] s2_adj_next [0:8];
    logic signed [EW-1:0] s2_row_reg [0:2];

    // stage 3: determinant partial products
    logic                 s3_v_reg;
    logic signed [PW:0]   s3_lo_reg [0:2];
    logic signed [PW-1:0] s3_hi_reg [0:2];
    logic signed [PW:0]   s3_lo_next [0:2];
    logic signed [PW-1:0] s3_hi_next [0:2];
    logic signed [PW-1:0] s3_adj_reg [0:8];

    // stage 4: determinant terms
    logic                 s4_v_reg;
    logic signed [TW-1:0] s4_t_reg [0:2];
    logic signed [TW-1:0] s4_t_next [0:2];
    logic signed [PW-1:0] s4_adj_reg [0:8];

    // stage 5: determinant
    logic                   s5_v_reg;
    logic signed [DETW-1:0] s5_det_reg;
    logic signed [DETW-1:0] s5_det_next;
    logic signed [PW-1:0]   s5_adj_reg [0:8];

    // stage 6: magnitudes and signs
    logic              s6_v_reg;
    logic [MAGW-1:0]   s6_mag_reg;
    logic [MAGW-1:0]   s6_mag_next;
    logic              s6_dneg_reg;
    logic [PW-2:0]     s6_absa_reg [0:8];
    logic [PW-2:0]     s6_absa_next [0:8];
    logic [8:0]        s6_aneg_reg;

    // divider pipeline, index 0 is loaded by stage 7
    logic              d_v_reg    [0:NDIV];
    logic              d_sing_reg [0:NDIV];
    logic [DVW-1:0]    d_dv_reg   [0:NDIV];
    logic [RW-1:0]     d_rem_reg  [0:NDIV][0:8];
    logic [QW-1:0]     d_q_reg    [0:NDIV][0:8];
    logic [8:0]        d_neg_reg  [0:NDIV];
    logic [8:0]        d_ovf_reg  [0:NDIV];
    logic [RW-1:0]     d_rem_next [1:NDIV][0:8];
    logic [QW-1:0]     d_q_next   [1:NDIV][0:8];
    logic [8:0]        d_ovf_next [1:NDIV];

    // stage 7 next values
    logic              s7_sing_next;
    logic [RW-1:0]     s7_x_next [0:8];

    // output register
    logic              done_reg;
    mat_out_t          result_reg;
    mat_out_t          result_next;
    logic [EW-1:0]     res_elem [0:8];
    logic [8:0]        res_sat;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign result    = result_reg;

    // configuration write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_W'(1);
        end
        else if (cfg_valid)
        begin
            thr_reg <= cfg_data;
        end
    end

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_v_reg <= 1'b0;
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            s4_v_reg <= 1'b0;
            s5_v_reg <= 1'b0;
            s6_v_reg <= 1'b0;
            done_reg <= 1'b0;
            for (int s = 0; s <= NDIV; s++)
            begin
                d_v_reg[s] <= 1'b0;
            end
        end
        else
        begin
            s0_v_reg   <= start;
            s1_v_reg   <= s0_v_reg;
            s2_v_reg   <= s1_v_reg;
            s3_v_reg   <= s2_v_reg;
            s4_v_reg   <= s3_v_reg;
            s5_v_reg   <= s4_v_reg;
            s6_v_reg   <= s5_v_reg;
            d_v_reg[0] <= s6_v_reg;
            for (int s = 1; s <= NDIV; s++)
            begin
                d_v_reg[s] <= d_v_reg[s-1];
            end
            done_reg <= d_v_reg[NDIV];
        end
    end

    // stage 0: unpack the transaction
    always_comb
    begin
        s0_a_next[0] = matrix.m00;
        s0_a_next[1] = matrix.m01;
        s0_a_next[2] = matrix.m02;
        s0_a_next[3] = matrix.m10;
        s0_a_next[4] = matrix.m11;
        s0_a_next[5] = matrix.m12;
        s0_a_next[6] = matrix.m20;
        s0_a_next[7] = matrix.m21;
        s0_a_next[8] = matrix.m22;
    end

    // stages 1, 2: cofactor products and differences; stages 6, 7: |adj| and dividends
    for (genvar k = 0; k < 9; k++)
    begin : g_adj
        always_comb
        begin
            s1_pa_next[k]  = s0_a_reg[ADJ_TERMS[k][0]] * s0_a_reg[ADJ_TERMS[k][1]];
            s1_pb_next[k]  = s0_a_reg[ADJ_TERMS[k][2]] * s0_a_reg[ADJ_TERMS[k][3]];
            s2_adj_next[k] = s1_pa_reg[k] - s1_pb_reg[k];
            s6_absa_next[k] = (PW-1)'(s5_adj_reg[k][PW-1] ? -s5_adj_reg[k] : s5_adj_reg[k]);
            s7_x_next[k]   = (RW'(s6_absa_reg[k]) << SHN) + RW'(s6_mag_reg);
        end
    end

    // stages 3 and 4: first-row times cofactor, split into halves
    for (genvar j = 0; j < 3; j++)
    begin : g_det
        always_comb
        begin
            s3_lo_next[j] = s2_row_reg[j] * $signed({1'b0, s2_adj_reg[3*j][EW-1:0]});
            s3_hi_next[j] = s2_row_reg[j] * $signed(s2_adj_reg[3*j][PW-1:EW]);
            s4_t_next[j]  = (TW'(s3_hi_reg[j]) <<< EW) + TW'(s3_lo_reg[j]);
        end
    end

    // stages 5, 6, 7: determinant, magnitude, singular test
    always_comb
    begin
        s5_det_next  = DETW'(s4_t_reg[0]) + DETW'(s4_t_reg[1]) + DETW'(s4_t_reg[2]);
        s6_mag_next  = MAGW'(s5_det_reg[DETW-1] ? -s5_det_reg : s5_det_reg);
        s7_sing_next = (s6_mag_reg <= (MAGW'(thr_reg) << (2 * FB)));
    end

    // front pipeline payload
    always_ff @(posedge clk)
    begin
        s0_a_reg    <= s0_a_next;
        s1_pa_reg   <= s1_pa_next;
        s1_pb_reg   <= s1_pb_next;
        s1_row_reg  <= s0_a_reg[0:2];
        s2_adj_reg  <= s2_adj_next;
        s2_row_reg  <= s1_row_reg;
        s3_lo_reg   <= s3_lo_next;
        s3_hi_reg   <= s3_hi_next;
        s3_adj_reg  <= s2_adj_reg;
        s4_t_reg    <= s4_t_next;
        s4_adj_reg  <= s3_adj_reg;
        s5_det_reg  <= s5_det_next;
        s5_adj_reg  <= s4_adj_reg;
        s6_mag_reg  <= s6_mag_next;
        s6_dneg_reg <= s5_det_reg[DETW-1];
        s6_absa_reg <= s6_absa_next;
        for (int k = 0; k < 9; k++)
        begin
            s6_aneg_reg[k] <= s5_adj_reg[k][PW-1];
        end
        // stage 7 loads the divider input
        d_sing_reg[0] <= s7_sing_next;
        d_dv_reg[0]   <= DVW'(s6_mag_reg) << 1;
        d_neg_reg[0]  <= s6_aneg_reg ^ {9{s6_dneg_reg}};
        d_ovf_reg[0]  <= '0;
        d_rem_reg[0]  <= s7_x_next;
        for (int k = 0; k < 9; k++)
        begin
            d_q_reg[0][k] <= '0;
        end
    end

    // divider: the first stage flags quotients that exceed QW bits,
    // the rest give one restoring quotient bit each, MSB first
    for (genvar s = 1; s <= NDIV; s++)
    begin : g_div
        localparam int SH = NDIV - s;
        for (genvar k = 0; k < 9; k++)
        begin : g_lane
            if (s == 1)
            begin : g_ovf
                always_comb
                begin
                    d_rem_next[s][k] = d_rem_reg[s-1][k];
                    d_q_next[s][k]   = d_q_reg[s-1][k];
                    d_ovf_next[s][k] = (CW'(d_rem_reg[s-1][k]) >= (CW'(d_dv_reg[s-1]) << SH));
                end
            end
            else
            begin : g_bit
                logic ge;
                always_comb
                begin
                    ge = (CW'(d_rem_reg[s-1][k]) >= (CW'(d_dv_reg[s-1]) << SH));
                    d_rem_next[s][k] = d_rem_reg[s-1][k];
                    d_q_next[s][k]   = d_q_reg[s-1][k];
                    d_ovf_next[s][k] = d_ovf_reg[s-1][k];
                    if (ge)
                    begin
                        d_rem_next[s][k]   = d_rem_reg[s-1][k] - RW'(CW'(d_dv_reg[s-1]) << SH);
                        d_q_next[s][k][SH] = 1'b1;
                    end
                end
            end
        end

        always_ff @(posedge clk)
        begin
            d_sing_reg[s] <= d_sing_reg[s-1];
            d_dv_reg[s]   <= d_dv_reg[s-1];
            d_neg_reg[s]  <= d_neg_reg[s-1];
            d_ovf_reg[s]  <= d_ovf_next[s];
            d_rem_reg[s]  <= d_rem_next[s];
            d_q_reg[s]    <= d_q_next[s];
        end
    end

    // clamp, apply sign, pack
    for (genvar k = 0; k < 9; k++)
    begin : g_out
        logic [QW-1:0] lim;
        logic [QW-1:0] qc;
        always_comb
        begin
            lim        = d_neg_reg[NDIV][k] ? LIM_NEG : LIM_POS;
            res_sat[k] = d_ovf_reg[NDIV][k] || (d_q_reg[NDIV][k] > lim);
            qc         = res_sat[k] ? lim : d_q_reg[NDIV][k];
            res_elem[k] = d_neg_reg[NDIV][k] ? EW'(-qc) : EW'(qc);
            if (d_sing_reg[NDIV])
            begin
                res_elem[k] = '0;
            end
        end
    end

    always_comb
    begin
        result_next.r00       = res_elem[0];
        result_next.r01       = res_elem[1];
        result_next.r02       = res_elem[2];
        result_next.r10       = res_elem[3];
        result_next.r11       = res_elem[4];
        result_next.r12       = res_elem[5];
        result_next.r20       = res_elem[6];
        result_next.r21       = res_elem[7];
        result_next.r22       = res_elem[8];
        result_next.singular  = d_sing_reg[NDIV];
        result_next.saturated = !d_sing_reg[NDIV] && (|res_sat);
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench for matrix3_inverse
// Drives matrices through the start/busy command port, predicts each inverse
// with exact wide integer arithmetic and checks every result in order.
// Several zero_threshold settings are exercised, extremes included.
// ----------------------------------------------------------------------------
module tb;
    import mi3_pkg::*;

    localparam int LATENCY = 43;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    mat_in_t          matrix;
    logic             done;
    mat_out_t         result;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [THR_W-1:0] cfg_data;

    // predictor copy of the register
    logic [THR_W-1:0] thr_model;
    mat_out_t         inv_queue[$];
    int               err_count;

    matrix3_inverse u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .matrix    (matrix),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // run limit
    initial
    begin
        #50ms;
        $display("tb: FAIL");
        $finish;
    end

    task automatic report(input string what, input logic [31:0] got,
                          input logic [31:0] exp);
        $display("tb: mismatch %s got %h exp %h", what, got, exp);
        err_count++;
    endtask

    // inverse of one matrix, exact products then one rounded division
    function automatic mat_out_t predict_inverse(input mat_in_t m);
        logic signed [255:0] a[9];
        logic signed [255:0] adj[9];
        logic signed [255:0] det;
        logic signed [255:0] q;
        logic [255:0]        mag;
        logic [255:0]        num;
        logic [255:0]        uq;
        logic [31:0]         v[9];
        bit                  neg;
        bit                  sat;
        mat_out_t            r;
        a[0] = 256'(m.m00); a[1] = 256'(m.m01); a[2] = 256'(m.m02);
        a[3] = 256'(m.m10); a[4] = 256'(m.m11); a[5] = 256'(m.m12);
        a[6] = 256'(m.m20); a[7] = 256'(m.m21); a[8] = 256'(m.m22);
        for (int k = 0; k < 9; k++)
            adj[k] = a[ADJ_TERMS[k][0]] * a[ADJ_TERMS[k][1]]
                   - a[ADJ_TERMS[k][2]] * a[ADJ_TERMS[k][3]];
        det = a[0] * adj[0] + a[1] * adj[3] + a[2] * adj[6];
        mag = (det < 0) ? -det : det;
        sat = 1'b0;
        r = '0;
        if (mag <= ({240'd0, thr_model} << (2 * FB)))
        begin
            r.singular = 1'b1;
            return r;
        end
        for (int k = 0; k < 9; k++)
        begin
            neg = (adj[k] < 0) ^ (det < 0);
            num = ((adj[k] < 0) ? -adj[k] : adj[k]) << (2 * FB);
            uq = ((num << 1) + mag) / (mag << 1);
            if (!neg && uq > 256'h7fffffff)
            begin
                uq = 256'h7fffffff;
                sat = 1'b1;
            end
            else if (neg && uq > 256'h80000000)
            begin
                uq = 256'h80000000;
                sat = 1'b1;
            end
            q = neg ? -uq : uq;
            v[k] = q[31:0];
        end
        r.r00 = v[0]; r.r01 = v[1]; r.r02 = v[2];
        r.r10 = v[3]; r.r11 = v[4]; r.r12 = v[5];
        r.r20 = v[6]; r.r21 = v[7]; r.r22 = v[8];
        r.saturated = sat;
        return r;
    endfunction

    // result checker
    always @(posedge clk)
    begin
        mat_out_t e;
        if (rst_n && done)
        begin
            if (inv_queue.size() == 0)
                report("unexpected result", 32'd0, 32'd0);
            else
            begin
                e = inv_queue.pop_front();
                if (result.r00 !== e.r00) report("r00", result.r00, e.r00);
                if (result.r01 !== e.r01) report("r01", result.r01, e.r01);
                if (result.r02 !== e.r02) report("r02", result.r02, e.r02);
                if (result.r10 !== e.r10) report("r10", result.r10, e.r10);
                if (result.r11 !== e.r11) report("r11", result.r11, e.r11);
                if (result.r12 !== e.r12) report("r12", result.r12, e.r12);
                if (result.r20 !== e.r20) report("r20", result.r20, e.r20);
                if (result.r21 !== e.r21) report("r21", result.r21, e.r21);
                if (result.r22 !== e.r22) report("r22", result.r22, e.r22);
                if (result.singular !== e.singular)
                    report("singular", 32'(result.singular), 32'(e.singular));
                if (result.saturated !== e.saturated)
                    report("saturated", 32'(result.saturated), 32'(e.saturated));
            end
        end
    end

    // one matrix transaction with a random lead-in gap when gaps is set;
    // start stays high into the next transaction when there is no gap
    task automatic send_matrix(input mat_in_t m, input bit gaps);
        int gap;
        gap = gaps ? $urandom_range(19, 0) : 0;
        if (gaps && $urandom_range(3, 0) == 0)
            gap = 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        matrix <= m;
        start  <= 1'b1;
        do @(posedge clk); while (busy);
        inv_queue.push_back(predict_inverse(m));
        @(negedge clk);
    endtask

    task automatic drain;
        start <= 1'b0;
        while (inv_queue.size() != 0) @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
    endtask

    task automatic write_threshold(input logic [THR_W-1:0] thr);
        drain();
        cfg_data  <= thr;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        thr_model = thr;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic mat_in_t diag(input logic [31:0] d);
        mat_in_t m;
        m = '0;
        m.m00 = d; m.m11 = d; m.m22 = d;
        return m;
    endfunction

    function automatic logic [31:0] rand_elem(input int mode);
        case (mode)
            0: return $urandom();
            1: return $signed($urandom_range(8 << FB, 0)) - (4 << FB);
            2: return $signed($urandom_range(255, 0)) - 128;
            default:
                case ($urandom_range(3, 0))
                    0: return 32'h80000000;
                    1: return 32'h7fffffff;
                    2: return 32'd0;
                    default: return 32'h00010000;
                endcase
        endcase
    endfunction

    function automatic mat_in_t rand_matrix;
        mat_in_t m;
        logic [31:0] e[9];
        int mode;
        mode = $urandom_range(4, 0);
        for (int k = 0; k < 9; k++)
            e[k] = rand_elem(mode == 4 ? $urandom_range(3, 0) : mode);
        // sometimes make a row a copy of another, forcing singularity
        if ($urandom_range(7, 0) == 0)
            for (int k = 0; k < 3; k++)
                e[6 + k] = e[k];
        m.m00 = e[0]; m.m01 = e[1]; m.m02 = e[2];
        m.m10 = e[3]; m.m11 = e[4]; m.m12 = e[5];
        m.m20 = e[6]; m.m21 = e[7]; m.m22 = e[8];
        return m;
    endfunction

    // identity, scaled diagonals, extremes, singular and saturating cases
    task automatic test_directed;
        mat_in_t m;
        send_matrix(diag(32'h00010000), 1'b0);
        send_matrix(diag(32'h00020000), 1'b0);
        send_matrix(diag(32'hffff0000), 1'b0);
        send_matrix(diag(32'h00000003), 1'b0);
        send_matrix(diag(32'h00000100), 1'b0);
        send_matrix(diag(32'h7fffffff), 1'b0);
        send_matrix(diag(32'h80000000), 1'b0);
        send_matrix('0, 1'b0);
        send_matrix('1, 1'b0);
        send_matrix({9{32'h80000000}}, 1'b0);
        send_matrix({9{32'h7fffffff}}, 1'b0);
        m = diag(32'h00010000);
        m.m01 = 32'h80000000; m.m12 = 32'h7fffffff; m.m20 = 32'h80000000;
        send_matrix(m, 1'b0);
        m = diag(32'h00000001);
        m.m22 = 32'h80000000;
        send_matrix(m, 1'b0);
        m = diag(32'h00008000);
        m.m02 = 32'hffff8000;
        send_matrix(m, 1'b0);
        m = '0;
        m.m01 = 32'h00010000; m.m12 = 32'h00010000; m.m20 = 32'h00010000;
        send_matrix(m, 1'b0);
        m = '0;
        m.m02 = 32'hfffe0000; m.m11 = 32'h00030000; m.m20 = 32'h00050000;
        send_matrix(m, 1'b0);
    endtask

    task automatic test_threshold_extremes;
        write_threshold(16'hffff);
        send_matrix(diag(32'h00010000), 1'b0);
        send_matrix(diag(32'h00280000), 1'b0);
        send_matrix(diag(32'h00290000), 1'b0);
        write_threshold(16'd0);
        send_matrix(diag(32'h00000001), 1'b0);
        send_matrix('0, 1'b0);
        write_threshold(16'd1);
        send_matrix(diag(32'h00010000), 1'b0);
        send_matrix(diag(32'h00010001), 1'b0);
    endtask

    task automatic test_random(input int count, input logic [THR_W-1:0] thr);
        bit gaps;
        write_threshold(thr);
        for (int i = 0; i < count; i++)
        begin
            if (i % 25 == 0)
                gaps = $urandom_range(1, 0);
            send_matrix(rand_matrix(), gaps);
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        start     = 1'b0;
        matrix    = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        err_count = 0;
        thr_model = 16'd1;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_threshold_extremes();
        test_random(100, 16'd1);
        test_random(100, 16'd0);
        test_random(100, 16'($urandom()));
        test_random(100, 16'hffff);
        drain();

        if (err_count == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end
endmodule

/* files.f */
sv/mi3_pkg.sv
sv/matrix3_inverse.sv
tb/tb.sv
